// ----- design/pds_hfp_pkg.sv -----
// Shared types, header layout tables and segment lookup for the PDS header parser.
`timescale 1ns / 1ps
`default_nettype none
package pds_hfp_pkg;

  // Field tags
  localparam logic [4:0] FID_TYPE        = 5'd0;
  localparam logic [4:0] FID_NEXT        = 5'd1;
  localparam logic [4:0] FID_FLAGS       = 5'd2;
  localparam logic [4:0] FID_ACK_PSN_OFF = 5'd8;
  localparam logic [4:0] FID_PROBE       = 5'd9;
  localparam logic [4:0] FID_CC_TYPE     = 5'd11;
  localparam logic [4:0] FID_CC_BITS     = 5'd12;
  localparam logic [4:0] FID_END         = 5'd25;
  localparam logic [4:0] FID_PAD         = 5'd31;

  localparam int FLAG_PROBE_BIT = 3;
  localparam int NUM_KINDS      = 11;
  localparam int MAX_SEGS       = 10;

  // layout kind per header type
  localparam logic [3:0] KIND_OF_TYPE [32] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd7, 4'd7, 4'd10, 4'd3,
    4'd4, 4'd5, 4'd8, 4'd6, 4'd9, 4'd2, 4'd2, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  localparam logic [3:0] SEG_COUNT [NUM_KINDS] = '{
    4'd0, 4'd4, 4'd5, 4'd4, 4'd9, 4'd10, 4'd5, 4'd1, 4'd6, 4'd8, 4'd1
  };

  localparam logic [5:0] TOTAL_LEN [NUM_KINDS] = '{
    6'd2, 6'd12, 6'd16, 6'd12, 6'd32, 6'd44, 6'd16, 6'd6, 6'd16, 6'd28, 6'd4
  };

  localparam logic [4:0] SEG_ID [NUM_KINDS][MAX_SEGS] = '{
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd3,  5'd4,  5'd5,  5'd6,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd8,  5'd10, 5'd5,  5'd6,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd8,  5'd10, 5'd5,  5'd6,  5'd11, 5'd13, 5'd14, 5'd15, 5'd16, 5'd0},
    '{5'd8,  5'd10, 5'd5,  5'd6,  5'd11, 5'd13, 5'd14, 5'd15, 5'd17, 5'd18},
    '{5'd9,  5'd4,  5'd5,  5'd6,  5'd19, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd20, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd21, 5'd22, 5'd23, 5'd5,  5'd6,  5'd24, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd21, 5'd22, 5'd23, 5'd5,  5'd6,  5'd24, 5'd17, 5'd18, 5'd0,  5'd0},
    '{5'd31, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0}
  };

  localparam logic [3:0] SEG_LEN [NUM_KINDS][MAX_SEGS] = '{
    '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd1, 4'd1, 4'd2, 4'd8, 4'd8, 4'd0},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd1, 4'd1, 4'd2, 4'd8, 4'd8, 4'd8},
    '{4'd2, 4'd4, 4'd2, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd4, 4'd2, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd1, 4'd1, 4'd4, 4'd2, 4'd2, 4'd4, 4'd8, 4'd4, 4'd0, 4'd0},
    '{4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  typedef enum logic [1:0] {
    JK_NONE,  // no body item (padding or mid-field byte)
    JK_PRO,   // prologue word: type, next/ctl, flags
    JK_FLD,   // one complete field
    JK_CCB    // cc type / cc bits byte
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [4:0]  fid;
    logic [63:0] value;
    logic        hdr_end;
    logic [5:0]  end_len;
  } job_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] fid;
  } seg_hit_t;

  // Does the byte at position pos close a segment of the given layout?
  function automatic seg_hit_t seg_lookup(input logic [3:0] kind, input logic [5:0] pos);
    seg_hit_t   res;
    logic [5:0] off;
    logic       done;
    res  = '0;
    off  = 6'd2;
    done = 1'b0;
    for (int i = 0; i < MAX_SEGS; i++) begin
      if (!done) begin
        if (4'(i) < SEG_COUNT[kind]) begin
          off = off + 6'(SEG_LEN[kind][i]);
          if (pos < off) begin
            done = 1'b1;
          end else if (pos == off) begin
            res.hit = 1'b1;
            res.fid = SEG_ID[kind][i];
            done    = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/pds_hfp_in_if.sv -----
// Input channel: header bytes with start mark.
`timescale 1ns / 1ps
`default_nettype none
interface pds_hfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, data_byte, start_req, input ready);
  modport sink (input valid, data_byte, start_req, output ready);
endinterface
`default_nettype wire

// ----- design/pds_hfp_out_if.sv -----
// Result channel: tagged header fields.
`timescale 1ns / 1ps
`default_nettype none
interface pds_hfp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_id;
  logic [63:0] field_value;
  logic        last;

  modport source (output valid, field_id, field_value, last, input ready);
  modport sink (input valid, field_id, field_value, last, output ready);
endinterface
`default_nettype wire

// ----- design/pds_hfp_front.sv -----
// Front end: byte tracking, field gathering and job classification.
`timescale 1ns / 1ps
`default_nettype none
module pds_hfp_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_data_byte,
  input  wire                 in_start_req,
  input  wire                 q_full,
  output logic                push,
  output pds_hfp_pkg::job_t   job
);
  import pds_hfp_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic [4:0]  type_r, type_nxt;
  logic [6:0]  flags_r, flags_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        active_r, active_nxt;

  logic        accept;
  logic [63:0] acc_sh;
  logic [5:0]  pos_inc;
  logic [15:0] word;
  logic [4:0]  type_eff;
  logic [3:0]  kind_eff;
  seg_hit_t    seg;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign acc_sh   = {acc_r[55:0], in_data_byte};
  assign pos_inc  = pos_r + 6'd1;
  assign word     = acc_sh[15:0];
  assign type_eff = (pos_inc == 6'd2) ? word[15:11] : type_r;
  assign kind_eff = KIND_OF_TYPE[type_eff];
  assign seg      = seg_lookup(KIND_OF_TYPE[type_r], pos_inc);

  always_comb begin
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    flags_nxt  = flags_r;
    acc_nxt    = acc_r;
    active_nxt = active_r;
    job        = '0;
    push       = 1'b0;
    if (accept) begin
      if (in_start_req) begin
        active_nxt = 1'b1;
        pos_nxt    = 6'd1;
        acc_nxt    = {56'd0, in_data_byte};
      end else if (active_r) begin
        pos_nxt = pos_inc;
        acc_nxt = acc_sh;
        if (pos_inc == 6'd2) begin
          type_nxt  = word[15:11];
          flags_nxt = word[6:0];
          job.kind  = JK_PRO;
          job.value = {48'd0, word};
          acc_nxt   = '0;
        end else if (seg.hit) begin
          acc_nxt = '0;
          if (seg.fid == FID_CC_TYPE) begin
            job.kind  = JK_CCB;
            job.value = acc_sh;
          end else if (seg.fid == FID_ACK_PSN_OFF) begin
            // probe flag swaps the second ACK word
            job.kind  = JK_FLD;
            job.fid   = flags_r[FLAG_PROBE_BIT] ? FID_PROBE : FID_ACK_PSN_OFF;
            job.value = {48'd0, acc_sh[15:0]};
          end else if (seg.fid != FID_PAD) begin
            job.kind  = JK_FLD;
            job.fid   = seg.fid;
            job.value = acc_sh;
          end
        end
        if (pos_inc >= TOTAL_LEN[kind_eff]) begin
          job.hdr_end = 1'b1;
          job.end_len = TOTAL_LEN[kind_eff];
          active_nxt  = 1'b0;
          acc_nxt     = '0;
        end
        push = (job.kind != JK_NONE) || job.hdr_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      type_r   <= '0;
      flags_r  <= '0;
      acc_r    <= '0;
      active_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      type_r   <= type_nxt;
      flags_r  <= flags_nxt;
      acc_r    <= acc_nxt;
      active_r <= active_nxt;
    end
  end

  a_active_pos: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pos_r != 6'd0) && (pos_r <= 6'd44))
    else $error("byte position out of range while header active");

  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_start_req |=> active_r && (pos_r == 6'd1))
    else $error("start item did not restart the header");

  a_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
    push && job.hdr_end |=> !active_r && (acc_r == 64'd0))
    else $error("header end did not return to idle");

endmodule
`default_nettype wire

// ----- design/pds_hfp_queue.sv -----
// Short job queue between front end and result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module pds_hfp_queue #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wire pds_hfp_pkg::job_t push_job,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output pds_hfp_pkg::job_t   head
);
  import pds_hfp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- design/pds_hfp_back.sv -----
// Back end: expands each job into result items through the output register.
`timescale 1ns / 1ps
`default_nettype none
module pds_hfp_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  wire pds_hfp_pkg::job_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [4:0]          out_field_id,
  output logic [63:0]         out_field_value,
  output logic                out_last
);
  import pds_hfp_pkg::*;

  logic [1:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [4:0]  fid_r;
  logic [63:0] value_r;
  logic        last_r;

  logic [1:0]  body_cnt;
  logic [2:0]  total_cnt;
  logic        advance;
  logic        final_item;
  logic [4:0]  item_fid;
  logic [63:0] item_value;
  logic        item_last;

  always_comb begin
    unique case (q_head.kind)
      JK_PRO:  body_cnt = 2'd3;
      JK_CCB:  body_cnt = 2'd2;
      JK_FLD:  body_cnt = 2'd1;
      default: body_cnt = 2'd0;
    endcase
  end

  assign total_cnt  = {1'b0, body_cnt} + {2'b00, q_head.hdr_end};
  assign final_item = ({1'b0, idx_r} + 3'd1) == total_cnt;
  assign advance    = q_valid && (!valid_r || out_ready);
  assign q_pop      = advance && final_item;

  // select the item at the current index within the job
  always_comb begin
    item_fid   = FID_END;
    item_value = {58'd0, q_head.end_len};
    item_last  = 1'b1;
    if (idx_r < body_cnt) begin
      item_last = 1'b0;
      case (q_head.kind)
        JK_PRO: begin
          case (idx_r)
            2'd0: begin
              item_fid   = FID_TYPE;
              item_value = {59'd0, q_head.value[15:11]};
            end
            2'd1: begin
              item_fid   = FID_NEXT;
              item_value = {60'd0, q_head.value[10:7]};
            end
            default: begin
              item_fid   = FID_FLAGS;
              item_value = {57'd0, q_head.value[6:0]};
            end
          endcase
        end
        JK_CCB: begin
          if (idx_r == 2'd0) begin
            item_fid   = FID_CC_TYPE;
            item_value = {60'd0, q_head.value[7:4]};
          end else begin
            item_fid   = FID_CC_BITS;
            item_value = {60'd0, q_head.value[3:0]};
          end
        end
        default: begin
          item_fid   = q_head.fid;
          item_value = q_head.value;
        end
      endcase
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
      idx_nxt   = final_item ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fid_r   <= item_fid;
      value_r <= item_value;
      last_r  <= item_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_field_id    = fid_r;
  assign out_field_value = value_r;
  assign out_last        = last_r;

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (last_r == (fid_r == FID_END)))
    else $error("last flag and end tag disagree");

  a_mid_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> q_valid && ({1'b0, idx_r} < total_cnt))
    else $error("item index outside the head job");

  a_empty_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> total_cnt != 3'd0)
    else $error("queued job carries no items");

endmodule
`default_nettype wire

// ----- design/pds_header_field_parser.sv -----
// Top level of the PDS transport header field parser.
// Takes one header byte per cycle, in wire order; start_req marks the first byte of a
// header and restarts any header in progress. Each byte yields zero to four result items
// (tag, zero-extended value, last on the header-end item carrying the length in bytes),
// delivered one per cycle from an output register while the result side is ready. The
// front end classifies each byte in the cycle it is accepted and queues at most one job
// per byte in a QUEUE_DEPTH-entry job queue; the back end expands jobs into items. Input
// is stalled only while the job queue is full, which happens when the result side stalls
// or multi-item bytes (prologue, cc byte, header end) arrive faster than one item per
// cycle can drain them.
`timescale 1ns / 1ps
`default_nettype none
module pds_header_field_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire          clk,
  input  wire          rst_n,
  pds_hfp_in_if.sink   in_ch,
  pds_hfp_out_if.source out_ch
);
  import pds_hfp_pkg::*;

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  pds_hfp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_start_req (in_ch.start_req),
    .q_full       (q_full),
    .push         (q_push),
    .job          (q_push_job)
  );

  pds_hfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  pds_hfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_field_id    (out_ch.field_id),
    .out_field_value (out_ch.field_value),
    .out_last        (out_ch.last)
  );

endmodule
`default_nettype wire

// ----- bench/pds_hfp_field_checker.sv -----
// Field checker: watches both channels, predicts the parsed header fields and compares them.
`timescale 1ns / 1ps
module pds_hfp_field_checker (
  input  wire    clk,
  input  wire    rst_n,
  pds_hfp_in_if  in_mon,
  pds_hfp_out_if out_mon,
  output int     field_errors,
  output int     fields_owed
);
  import pds_hfp_pkg::*;

  // body field tags not named in the package
  localparam logic [4:0] F_CLEAR_PSN    = 5'd3;
  localparam logic [4:0] F_PSN          = 5'd4;
  localparam logic [4:0] F_SPDCID       = 5'd5;
  localparam logic [4:0] F_DPDCID       = 5'd6;
  localparam logic [4:0] F_REQ_CC_STATE = 5'd7;
  localparam logic [4:0] F_CACK_PSN     = 5'd10;
  localparam logic [4:0] F_MPR          = 5'd13;
  localparam logic [4:0] F_SACK_PSN     = 5'd14;
  localparam logic [4:0] F_SACK_BITMAP  = 5'd15;
  localparam logic [4:0] F_ACK_CC_STATE = 5'd16;
  localparam logic [4:0] F_CCX_HI       = 5'd17;
  localparam logic [4:0] F_CCX_LO       = 5'd18;
  localparam logic [4:0] F_CP_PAYLOAD   = 5'd19;
  localparam logic [4:0] F_PKT_ID       = 5'd20;
  localparam logic [4:0] F_NACK_CODE    = 5'd21;
  localparam logic [4:0] F_VENDOR_CODE  = 5'd22;
  localparam logic [4:0] F_NACK_PSN     = 5'd23;
  localparam logic [4:0] F_NACK_PAYLOAD = 5'd24;

  localparam int REPORT_LIMIT = 10;

  typedef enum logic [3:0] {
    LAY_PROLOGUE, LAY_REQ, LAY_CC_REQ, LAY_ACK, LAY_ACK_CC, LAY_ACK_CCX,
    LAY_CP, LAY_RUDI, LAY_NACK, LAY_NACK_CCX, LAY_UUD
  } layout_e;

  localparam layout_e LAYOUT_BY_TYPE [32] = '{
    LAY_PROLOGUE, LAY_PROLOGUE, LAY_REQ,      LAY_REQ,
    LAY_RUDI,     LAY_RUDI,     LAY_UUD,      LAY_ACK,
    LAY_ACK_CC,   LAY_ACK_CCX,  LAY_NACK,     LAY_CP,
    LAY_NACK_CCX, LAY_CC_REQ,   LAY_CC_REQ,   LAY_PROLOGUE,
    LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE,
    LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE,
    LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE,
    LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE, LAY_PROLOGUE
  };

  typedef struct packed {
    logic [4:0]  id;
    logic [63:0] value;
    logic        last;
  } field_item_t;

  field_item_t field_q[$];
  field_item_t want;

  // parser state
  logic [5:0]  hdr_pos;
  logic [4:0]  hdr_type;
  logic [6:0]  hdr_flags;
  logic [63:0] field_acc;
  logic        in_header;

  function automatic logic [5:0] header_length(input layout_e lay);
    case (lay)
      LAY_REQ, LAY_ACK:       return 6'd12;
      LAY_CC_REQ, LAY_CP:     return 6'd16;
      LAY_NACK:               return 6'd16;
      LAY_ACK_CC:             return 6'd32;
      LAY_ACK_CCX:            return 6'd44;
      LAY_NACK_CCX:           return 6'd28;
      LAY_RUDI:               return 6'd6;
      LAY_UUD:                return 6'd4;
      default:                return 6'd2;
    endcase
  endfunction

  // Tag of the field whose last byte sits at pos; FID_PAD when none ends there.
  // Padding and reserved bytes simply never close a field.
  function automatic logic [4:0] field_closing(input layout_e lay, input logic [5:0] pos);
    logic [4:0] f;
    f = FID_PAD;
    case (lay)
      LAY_REQ, LAY_CC_REQ: begin
        case (pos)
          6'd4:  f = F_CLEAR_PSN;
          6'd8:  f = F_PSN;
          6'd10: f = F_SPDCID;
          6'd12: f = F_DPDCID;
          6'd16: if (lay == LAY_CC_REQ) f = F_REQ_CC_STATE;
          default: ;
        endcase
      end
      LAY_ACK, LAY_ACK_CC, LAY_ACK_CCX: begin
        case (pos)
          6'd4:  f = FID_ACK_PSN_OFF;
          6'd8:  f = F_CACK_PSN;
          6'd10: f = F_SPDCID;
          6'd12: f = F_DPDCID;
          6'd13: f = FID_CC_TYPE;
          6'd14: f = F_MPR;
          6'd16: f = F_SACK_PSN;
          6'd24: f = F_SACK_BITMAP;
          6'd32: f = (lay == LAY_ACK_CCX) ? F_CCX_HI : F_ACK_CC_STATE;
          6'd40: f = F_CCX_LO;
          default: ;
        endcase
      end
      LAY_CP: begin
        case (pos)
          6'd4:  f = FID_PROBE;
          6'd8:  f = F_PSN;
          6'd10: f = F_SPDCID;
          6'd12: f = F_DPDCID;
          6'd16: f = F_CP_PAYLOAD;
          default: ;
        endcase
      end
      LAY_RUDI: if (pos == 6'd6) f = F_PKT_ID;
      LAY_NACK, LAY_NACK_CCX: begin
        case (pos)
          6'd3:  f = F_NACK_CODE;
          6'd4:  f = F_VENDOR_CODE;
          6'd8:  f = F_NACK_PSN;
          6'd10: f = F_SPDCID;
          6'd12: f = F_DPDCID;
          6'd16: f = F_NACK_PAYLOAD;
          6'd24: f = F_CCX_HI;
          6'd28: f = F_CCX_LO;
          default: ;
        endcase
      end
      default: ;
    endcase
    return f;
  endfunction

  function automatic void owe_field(input logic [4:0] id, input logic [63:0] v,
                                    input logic l);
    field_item_t it;
    it.id    = id;
    it.value = v;
    it.last  = l;
    field_q.push_back(it);
  endfunction

  task automatic parse_header_byte(input logic [7:0] b, input logic st);
    logic [15:0] word;
    logic [4:0]  fid;
    logic [5:0]  total;
    if (st) begin
      in_header = 1'b1;
      hdr_pos   = 6'd1;
      field_acc = {56'd0, b};
      return;
    end
    if (!in_header) return;
    field_acc = {field_acc[55:0], b};
    hdr_pos   = hdr_pos + 6'd1;
    if (hdr_pos == 6'd2) begin
      word      = field_acc[15:0];
      hdr_type  = word[15:11];
      hdr_flags = word[6:0];
      owe_field(FID_TYPE, 64'(hdr_type), 1'b0);
      owe_field(FID_NEXT, 64'(word[10:7]), 1'b0);
      owe_field(FID_FLAGS, 64'(hdr_flags), 1'b0);
      field_acc = '0;
    end else begin
      fid = field_closing(LAYOUT_BY_TYPE[hdr_type], hdr_pos);
      if (fid != FID_PAD) begin
        if (fid == FID_CC_TYPE) begin
          owe_field(FID_CC_TYPE, 64'(field_acc[7:4]), 1'b0);
          owe_field(FID_CC_BITS, 64'(field_acc[3:0]), 1'b0);
        end else if (fid == FID_ACK_PSN_OFF) begin
          // probe flag reroutes the ACK second word
          owe_field(hdr_flags[FLAG_PROBE_BIT] ? FID_PROBE : FID_ACK_PSN_OFF,
                    64'(field_acc[15:0]), 1'b0);
        end else begin
          owe_field(fid, field_acc, 1'b0);
        end
        field_acc = '0;
      end
    end
    total = header_length(LAYOUT_BY_TYPE[hdr_type]);
    if (hdr_pos >= total) begin
      owe_field(FID_END, 64'(total), 1'b1);
      in_header = 1'b0;
      field_acc = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      field_q.delete();
      hdr_pos      = '0;
      hdr_type     = '0;
      hdr_flags    = '0;
      field_acc    = '0;
      in_header    = 1'b0;
      field_errors = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        parse_header_byte(in_mon.data_byte, in_mon.start_req);
      if (out_mon.valid && out_mon.ready) begin
        if (field_q.size() == 0) begin
          if (field_errors < REPORT_LIMIT)
            $display("%0t: unexpected field id %0d value %h last %b, nothing outstanding",
                     $realtime, out_mon.field_id, out_mon.field_value, out_mon.last);
          field_errors++;
        end else begin
          want = field_q.pop_front();
          if (out_mon.field_id !== want.id || out_mon.field_value !== want.value ||
              out_mon.last !== want.last) begin
            if (field_errors < REPORT_LIMIT)
              $display({"%0t: field mismatch: expected id %0d value %h last %b, ",
                        "got id %0d value %h last %b"},
                       $realtime, want.id, want.value, want.last,
                       out_mon.field_id, out_mon.field_value, out_mon.last);
            field_errors++;
          end
        end
      end
    end
    fields_owed = field_q.size();
  end

endmodule

// ----- bench/tb.sv -----
// Top of the header parser bench: clock, reset, byte stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module tb;
  import pds_hfp_pkg::*;

  localparam int ITEM_TARGET = 460;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT = 20000;

  localparam logic [4:0] HT_UNKNOWN_MIN = 5'd0;
  localparam logic [4:0] HT_RUD_REQ     = 5'd2;
  localparam logic [4:0] HT_ROD_REQ     = 5'd3;
  localparam logic [4:0] HT_RUDI_REQ    = 5'd4;
  localparam logic [4:0] HT_RUDI_RESP   = 5'd5;
  localparam logic [4:0] HT_UUD_REQ     = 5'd6;
  localparam logic [4:0] HT_ACK         = 5'd7;
  localparam logic [4:0] HT_ACK_CC      = 5'd8;
  localparam logic [4:0] HT_ACK_CCX     = 5'd9;
  localparam logic [4:0] HT_NACK        = 5'd10;
  localparam logic [4:0] HT_CP          = 5'd11;
  localparam logic [4:0] HT_NACK_CCX    = 5'd12;
  localparam logic [4:0] HT_RUD_CC_REQ  = 5'd13;
  localparam logic [4:0] HT_ROD_CC_REQ  = 5'd14;
  localparam logic [4:0] HT_UNKNOWN_MAX = 5'd31;

  localparam logic [4:0] KNOWN_TYPES [13] = '{
    HT_RUD_REQ, HT_ROD_REQ, HT_RUDI_REQ, HT_RUDI_RESP, HT_UUD_REQ, HT_ACK, HT_ACK_CC,
    HT_ACK_CCX, HT_NACK, HT_CP, HT_NACK_CCX, HT_RUD_CC_REQ, HT_ROD_CC_REQ
  };

  logic clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   bytes_sent;
  int   type_turn;
  logic hold_asked;
  logic hold_taken;
  int   hold_left;
  int   field_errors;
  int   fields_owed;

  pds_hfp_in_if  in_ch ();
  pds_hfp_out_if out_ch ();

  pds_header_field_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pds_hfp_field_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .field_errors (field_errors),
    .fields_owed  (fields_owed)
  );

  always #10 clk = ~clk;

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_taken   = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.start_req <= st;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Prologue word then body bytes; nbytes counts the whole header as sent,
  // so a short count gives a truncated header.
  task automatic send_header(input logic [4:0] t, input logic [3:0] nc, input logic [6:0] fl,
                             input int nbytes, input logic [7:0] and_m, input logic [7:0] or_m);
    logic [15:0] word;
    logic [7:0]  b;
    word = {t, nc, fl};
    for (int i = 0; i < nbytes; i++) begin
      if (i == 0)      b = word[15:8];
      else if (i == 1) b = word[7:0];
      else             b = (8'($urandom) & and_m) | or_m;
      push_byte(b, i == 0);
      bytes_sent++;
    end
  endtask

  task automatic wait_results_drained();
    int spins;
    in_ch.valid <= 1'b0;
    @(negedge clk);
    spins = 0;
    while (fields_owed != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
  endtask

  task automatic random_headers(input int upto);
    logic [4:0] t;
    logic [6:0] fl;
    logic [7:0] and_m;
    logic [7:0] or_m;
    int         full;
    int         r;
    while (bytes_sent < upto) begin
      fl = 7'($urandom);
      if ($urandom_range(99) < 15) begin
        t = 5'($urandom_range(31));
      end else begin
        t = KNOWN_TYPES[type_turn % 13];
        // alternate passes over the known types with and without probe
        fl[FLAG_PROBE_BIT] = ((type_turn / 13) % 2) == 1;
        type_turn++;
      end
      full = int'(TOTAL_LEN[KIND_OF_TYPE[t]]);
      r = $urandom_range(99);
      and_m = 8'hFF;
      or_m  = 8'h00;
      if (r < 8) begin
        and_m = 8'h00;
        or_m  = 8'hFF;
      end else if (r < 16) begin
        and_m = 8'h00;
      end
      r = $urandom_range(99);
      if (r < 78) begin
        send_header(t, 4'($urandom), fl, full, and_m, or_m);
      end else if (r < 92) begin
        // cut short; the next start mark restarts the parse
        send_header(t, 4'($urandom), fl, $urandom_range(full - 1, 1), and_m, or_m);
      end else begin
        repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.start_req = 1'b0;
    rst_n           = 1'b0;
    hold_asked      = 1'b0;
    send_idle_pct   = 6;
    recv_idle_pct   = 61;
    bytes_sent      = 0;
    type_turn       = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle bytes before any header are dropped
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // unknown types: prologue only, all ones and all zeros
    send_header(HT_UNKNOWN_MAX, 4'hF, 7'h7F, 2, 8'h00, 8'h00);
    send_header(HT_UNKNOWN_MIN, 4'h0, 7'h00, 2, 8'h00, 8'h00);
    // reserved word of UUD gives no field
    send_header(HT_UUD_REQ, 4'h5, 7'h2A, 4, 8'hFF, 8'h00);
    send_header(HT_RUDI_RESP, 4'hF, 7'h7F, 6, 8'h00, 8'hFF);
    // ACK abandoned mid-field by a new start mark
    send_header(HT_ACK, 4'h3, 7'h08, 3, 8'hFF, 8'h00);
    send_header(HT_UNKNOWN_MIN, 4'hA, 7'h55, 2, 8'hFF, 8'h00);
    // trailing byte after the end is ignored
    push_byte(8'hA5, 1'b0);

    random_headers(150);
    wait_results_drained();

    send_idle_pct = 61;
    recv_idle_pct = 6;
    random_headers(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked    = 1'b1;
    random_headers(ITEM_TARGET);

    wait_results_drained();
    repeat (8) @(negedge clk);
    if (field_errors == 0 && fields_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
